/* rtl/wheel_odometer_with_lap_core_macros.svh */
// Assertion macros shared by the checker; every property is sampled on clock and
// is off while reset is high.
`ifndef WHEEL_ODOMETER_WITH_LAP_CORE_MACROS_SVH
`define WHEEL_ODOMETER_WITH_LAP_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WOL_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wheel odometer check failed");

// Consequent must hold in the cycle after the antecedent.
`define WOL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wheel odometer check failed");

`endif

/* rtl/wol_pkg.sv */
package wol_pkg;

   localparam int INC_W      = 16;
   localparam int CIRC_W     = 16;
   localparam int PROD_W     = 32;
   localparam int DELTA_W    = 33;
   localparam int TOTAL_W    = 48;
   localparam int LAP_W      = 49;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 136;

   // flags of one input beat, carried alongside the lane products
   typedef struct packed {
      logic reset_request;
      logic buttons_sampled;
      logic start_button;
      logic stop_button;
   } ctrl_type;

   // stage advance strobes from the top level to the merging stage
   typedef struct packed {
      logic acc_enable;
      logic out_enable;
   } stage_en_type;

endpackage

/* rtl/wol_lane.sv */
module wol_lane (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [wol_pkg::CIRC_W-1:0]  circumference,
   input  logic [wol_pkg::INC_W-1:0]   increments,
   output logic [wol_pkg::PROD_W-1:0]  product
);

   logic [wol_pkg::PROD_W-1:0] product_ff;
   logic [wol_pkg::PROD_W-1:0] product_in;

   assign product_in = circumference * increments;

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

/* rtl/wol_merge.sv */
module wol_merge #(
   parameter int SUM_WIDTH = 48
) (
   input  logic                         clock,
   input  logic                         reset,
   input  wol_pkg::stage_en_type        stage_en,
   input  wol_pkg::ctrl_type            ctrl,
   input  logic [wol_pkg::PROD_W-1:0]   prod_left,
   input  logic [wol_pkg::PROD_W-1:0]   prod_right,
   output logic [wol_pkg::DELTA_W-1:0]  delta_distance,
   output logic [wol_pkg::TOTAL_W-1:0]  total_distance,
   output logic [wol_pkg::LAP_W-1:0]    lap_distance,
   output logic                         lap_done,
   output logic                         lap_indicator
);

   localparam int DW = (SUM_WIDTH > wol_pkg::LAP_W) ? SUM_WIDTH : wol_pkg::LAP_W;

   // accumulation stage
   logic [SUM_WIDTH-1:0]         sum_ff, sum_in;
   logic [SUM_WIDTH-1:0]         mark_ff, mark_in;
   logic                         running_ff, running_in;
   logic                         prev_start_ff, prev_start_in;
   logic                         prev_stop_ff, prev_stop_in;
   logic [wol_pkg::DELTA_W-1:0]  delta_ff, delta_in;
   logic                         done_ff, done_in;

   // output stage
   logic [wol_pkg::DELTA_W-1:0]  out_delta_ff;
   logic [wol_pkg::TOTAL_W-1:0]  out_total_ff, out_total_in;
   logic [wol_pkg::LAP_W-1:0]    out_lap_ff, out_lap_in;
   logic                         out_done_ff;
   logic                         out_ind_ff;

   logic [wol_pkg::DELTA_W-1:0]  delta_sum;
   logic [SUM_WIDTH:0]           sum_add;
   logic                         start_edge;
   logic                         stop_edge;
   logic [DW-1:0]                sum_ext;
   logic [DW-1:0]                lap_diff;

   // merge the two lanes
   assign delta_sum = {1'b0, prod_left} + {1'b0, prod_right};

   always_comb begin
      delta_in = ctrl.reset_request ? '0 : delta_sum;
      sum_add  = {1'b0, sum_ff} + (SUM_WIDTH + 1)'(delta_in);
      priority if (ctrl.reset_request) begin
         sum_in = '0;
      end else if (sum_add[SUM_WIDTH]) begin
         sum_in = '1;
      end else begin
         sum_in = sum_add[SUM_WIDTH-1:0];
      end

      // lap edges see the updated total; stop wins over start
      start_edge = ctrl.buttons_sampled && ctrl.start_button && !prev_start_ff;
      stop_edge  = ctrl.buttons_sampled && ctrl.stop_button && !prev_stop_ff;
      mark_in    = start_edge ? sum_in : mark_ff;
      priority if (stop_edge) begin
         running_in = 1'b0;
      end else if (start_edge) begin
         running_in = 1'b1;
      end else begin
         running_in = running_ff;
      end
      done_in       = stop_edge;
      prev_start_in = ctrl.buttons_sampled ? ctrl.start_button : prev_start_ff;
      prev_stop_in  = ctrl.buttons_sampled ? ctrl.stop_button : prev_stop_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff        <= '0;
         mark_ff       <= '0;
         running_ff    <= 1'b0;
         prev_start_ff <= 1'b0;
         prev_stop_ff  <= 1'b0;
      end else if (stage_en.acc_enable) begin
         sum_ff        <= sum_in;
         mark_ff       <= mark_in;
         running_ff    <= running_in;
         prev_start_ff <= prev_start_in;
         prev_stop_ff  <= prev_stop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.acc_enable) begin
         delta_ff <= delta_in;
         done_ff  <= done_in;
      end
   end

   // lap subtraction kept out of the accumulator loop
   always_comb begin
      sum_ext      = DW'(sum_ff);
      lap_diff     = sum_ext - DW'(mark_ff);
      out_total_in = sum_ext[wol_pkg::TOTAL_W-1:0];
      out_lap_in   = done_ff ? lap_diff[wol_pkg::LAP_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (stage_en.out_enable) begin
         out_delta_ff <= delta_ff;
         out_total_ff <= out_total_in;
         out_lap_ff   <= out_lap_in;
         out_done_ff  <= done_ff;
         out_ind_ff   <= running_ff;
      end
   end

   assign delta_distance = out_delta_ff;
   assign total_distance = out_total_ff;
   assign lap_distance   = out_lap_ff;
   assign lap_done       = out_done_ff;
   assign lap_indicator  = out_ind_ff;

endmodule

/* rtl/wheel_odometer_with_lap_core.sv */
// Wheel odometer with lap marker. Each request beat carries one sample period of
// left and right encoder increments; two lanes scale each by the wheel circumference
// in parallel and a merging stage adds them into the period distance and a saturating
// total (units of 1/72000 cm), then resolves lap start and stop edges. One beat is
// taken every cycle while the response side drains; a result passes three register
// stages (lane multiply, accumulate, lap subtraction into the output register) and is
// offered from the output register. A stalled response holds the whole pipeline and
// with it the request side. The total add-and-saturate feedback loop through sum_ff
// is what sets the one beat per cycle figure. Write the circumference on the csr
// channel only while no beat is in flight.
module wheel_odometer_with_lap_core #(
   parameter int SUM_WIDTH = 48
) (
   input  logic                             clock,
   input  logic                             reset,
   // csr write channel: wheel circumference in cm
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [wol_pkg::CIRC_W-1:0]       csr_data,
   // request: [15:0] left_increments, [31:16] right_increments, [32] reset_request,
   // [33] start_button, [34] stop_button, [39:35] zero
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [wol_pkg::REQ_DATA_W-1:0]   req_tdata,
   // request user: [0] buttons_sampled
   input  logic                             req_tuser,
   // response: [32:0] delta_distance, [80:33] total_distance, [129:81] lap_distance,
   // [130] lap_indicator, [135:131] zero
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [wol_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // response user: [0] lap_done
   output logic                             rsp_tuser
);

   logic [wol_pkg::CIRC_W-1:0]   circ_ff;
   logic                         v1_ff, v2_ff, v3_ff;
   wol_pkg::ctrl_type            ctrl_ff, ctrl_in;
   wol_pkg::stage_en_type        stage_en;
   logic                         advance;
   logic                         lane_enable;
   logic [wol_pkg::PROD_W-1:0]   prod_left, prod_right;
   logic [wol_pkg::DELTA_W-1:0]  delta_distance;
   logic [wol_pkg::TOTAL_W-1:0]  total_distance;
   logic [wol_pkg::LAP_W-1:0]    lap_distance;
   logic                         lap_done;
   logic                         lap_indicator;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         circ_ff <= '0;
      end else if (csr_valid) begin
         circ_ff <= csr_data;
      end
   end

   // whole pipeline moves unless the response register is full and stalled
   assign advance     = !v3_ff || rsp_tready;
   assign req_tready  = advance;
   assign lane_enable = advance && req_tvalid;
   assign stage_en.acc_enable = advance && v1_ff;
   assign stage_en.out_enable = advance && v2_ff;

   always_comb begin
      ctrl_in.reset_request   = req_tdata[32];
      ctrl_in.buttons_sampled = req_tuser;
      ctrl_in.start_button    = req_tdata[33];
      ctrl_in.stop_button     = req_tdata[34];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (lane_enable) begin
         ctrl_ff <= ctrl_in;
      end
   end

   wol_lane u_lane_left (
      .clock         (clock),
      .enable        (lane_enable),
      .circumference (circ_ff),
      .increments    (req_tdata[15:0]),
      .product       (prod_left)
   );

   wol_lane u_lane_right (
      .clock         (clock),
      .enable        (lane_enable),
      .circumference (circ_ff),
      .increments    (req_tdata[31:16]),
      .product       (prod_right)
   );

   wol_merge #(
      .SUM_WIDTH (SUM_WIDTH)
   ) u_merge (
      .clock          (clock),
      .reset          (reset),
      .stage_en       (stage_en),
      .ctrl           (ctrl_ff),
      .prod_left      (prod_left),
      .prod_right     (prod_right),
      .delta_distance (delta_distance),
      .total_distance (total_distance),
      .lap_distance   (lap_distance),
      .lap_done       (lap_done),
      .lap_indicator  (lap_indicator)
   );

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {5'b0, lap_indicator, lap_distance, total_distance, delta_distance};
   assign rsp_tuser  = lap_done;

endmodule

/* rtl/wol_checker.sv */
`include "wheel_odometer_with_lap_core_macros.svh"

module wol_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [wol_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                             rsp_tuser
);

   // a stalled response beat stays and holds its payload
   `WOL_ASSERT_NEXT(rsp_hold_valid, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `WOL_ASSERT_NEXT(rsp_hold_data, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))

   // a finished lap always leaves the indicator down
   `WOL_ASSERT_NOW(lap_done_clears_ind, rsp_tvalid && rsp_tuser, !rsp_tdata[130])

   // lap distance reads zero on beats without a stop edge
   `WOL_ASSERT_NOW(lap_zero_when_idle, rsp_tvalid && !rsp_tuser, rsp_tdata[129:81] == '0)

   // the pipeline is able to take a beat whenever the response side is free
   `WOL_ASSERT_NOW(req_ready_when_free, !rsp_tvalid, req_tready)

endmodule

bind wheel_odometer_with_lap_core wol_checker u_wol_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
